[hdl/tga_rle_pixel_decoder_defines.svh]
// Assertion macros shared by the decoder modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while reset is released
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/trd_pkg.sv]
package trd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_KIND    = 3'd0;
    localparam logic [2:0] CFG_PIXEL_SIZE    = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_TOP_DOWN      = 3'd4;
    localparam logic [2:0] CFG_PALETTE_COUNT = 3'd5;

    // image kinds
    localparam logic [1:0] KIND_RAW_TRUE = 2'd0;
    localparam logic [1:0] KIND_RLE_TRUE = 2'd1;
    localparam logic [1:0] KIND_RAW_MAP  = 2'd2;

    // pixel size codes
    localparam logic [1:0] PSIZE_INDEX = 2'd0;
    localparam logic [1:0] PSIZE_BGR   = 2'd1;
    localparam logic [1:0] PSIZE_BGRA  = 2'd2;

    // parser phases
    localparam logic [1:0] PH_PAL = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_PIX = 2'd2;

    // packet header fields and pixel constants
    localparam logic [7:0] HDR_RUN_FLAG   = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
    localparam logic [7:0] MAX_RUN        = 8'd128;
    localparam logic [12:0] MIN_WIDTH     = 13'd4;
    localparam logic [12:0] MIN_HEIGHT    = 13'd1;

    typedef struct packed {
        logic [1:0]  image_kind;
        logic [1:0]  pixel_size_code;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        top_down;
        logic [8:0]  palette_count;
    } t_cfg;

    // one decoded pixel with its repeat count
    typedef struct packed {
        logic [7:0]  count;
        logic [31:0] argb;
        logic        indexed;
        logic        index_oob;
    } t_job;

endpackage

[hdl/trd_ram.sv]
module trd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/trd_front.sv]
`include "tga_rle_pixel_decoder_defines.svh"

module trd_front import trd_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    output logic                  o_job_load,
    output t_job                  o_job,
    output logic                  o_pal_we,
    output logic [(PALETTE_DEPTH > 1 ? $clog2(PALETTE_DEPTH) : 1)-1:0] o_pal_waddr,
    output logic [23:0]           o_pal_wdata,
    output logic                  o_pal_re,
    output logic [(PALETTE_DEPTH > 1 ? $clog2(PALETTE_DEPTH) : 1)-1:0] o_pal_raddr
);

    localparam int PAW = PALETTE_DEPTH > 1 ? $clog2(PALETTE_DEPTH) : 1;

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_bii, n_bii;
    logic [23:0] r_asm, n_asm;
    logic [7:0]  r_rem, n_rem;
    logic        r_run, n_run;
    logic [8:0]  r_pal_idx, n_pal_idx;

    logic        rle;
    logic        hdr_path;
    logic        pix_path;
    logic        store_byte;
    logic [1:0]  bii_eff;
    logic [1:0]  last_bii;
    logic [9:0]  pal_idx_inc;

    assign rle         = (i_cfg.image_kind == KIND_RLE_TRUE);
    assign last_bii    = (i_cfg.pixel_size_code == PSIZE_BGR) ? 2'd2 : 2'd3;
    assign pal_idx_inc = {1'b0, r_pal_idx} + 10'd1;

    assign o_pal_waddr = r_pal_idx[PAW-1:0];
    assign o_pal_wdata = {i_byte, r_asm[15:0]};
    assign o_pal_raddr = i_byte[PAW-1:0];

    // byte parser: palette entries, packet headers, pixel assembly
    always_comb begin
        n_phase    = r_phase;
        n_bii      = r_bii;
        n_asm      = r_asm;
        n_rem      = r_rem;
        n_run      = r_run;
        n_pal_idx  = r_pal_idx;
        hdr_path   = 1'b0;
        pix_path   = 1'b0;
        store_byte = 1'b0;
        bii_eff    = r_bii;
        o_job_load = 1'b0;
        o_pal_we   = 1'b0;
        o_pal_re   = 1'b0;
        o_job      = '0;

        if (i_accept) begin
            case (r_phase)
                PH_PAL: begin
                    if (r_pal_idx < i_cfg.palette_count) begin
                        if (r_bii == 2'd2) begin
                            o_pal_we  = ({1'b0, r_pal_idx} < 10'(PALETTE_DEPTH));
                            n_pal_idx = pal_idx_inc[8:0];
                            n_bii     = 2'd0;
                            if (pal_idx_inc >= {1'b0, i_cfg.palette_count}) begin
                                n_phase = PH_HDR;
                            end
                        end else begin
                            store_byte = 1'b1;
                            n_bii      = r_bii + 2'd1;
                        end
                    end else begin
                        hdr_path = 1'b1;
                    end
                end
                PH_HDR:  hdr_path = 1'b1;
                PH_PIX:  pix_path = 1'b1;
                default: hdr_path = 1'b1;
            endcase

            // packet header, or the first byte of a raw pixel
            if (hdr_path) begin
                n_phase = PH_PIX;
                n_bii   = 2'd0;
                if (rle) begin
                    n_run = (i_byte & HDR_RUN_FLAG) != 8'd0;
                    n_rem = (i_byte & HDR_COUNT_MASK) + 8'd1;
                end else begin
                    n_run    = 1'b0;
                    n_rem    = 8'd1;
                    pix_path = 1'b1;
                    bii_eff  = 2'd0;
                end
            end

            // pixel bytes
            if (pix_path) begin
                if (i_cfg.pixel_size_code == PSIZE_INDEX) begin
                    o_job_load        = 1'b1;
                    o_pal_re          = 1'b1;
                    o_job.indexed     = 1'b1;
                    o_job.index_oob   = ({1'b0, i_byte} >= 9'(PALETTE_DEPTH));
                end else if (bii_eff < last_bii) begin
                    store_byte = 1'b1;
                    n_bii      = bii_eff + 2'd1;
                end else begin
                    o_job_load = 1'b1;
                    // a BGR pixel that already holds three bytes drops this one
                    if (i_cfg.pixel_size_code != PSIZE_BGR) begin
                        o_job.argb = {i_byte, r_asm};
                    end else if (bii_eff == 2'd3) begin
                        o_job.argb = {ALPHA_OPAQUE, r_asm};
                    end else begin
                        o_job.argb = {ALPHA_OPAQUE, i_byte, r_asm[15:0]};
                    end
                end

                if (o_job_load) begin
                    n_bii       = 2'd0;
                    o_job.count = (rle && n_run) ? ((n_rem == 8'd0) ? 8'd1 : n_rem) : 8'd1;
                    if (rle && !n_run && n_rem > 8'd1) begin
                        n_rem   = n_rem - 8'd1;
                        n_phase = PH_PIX;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            end

            // gather pixel or palette bytes, blue first
            if (store_byte) begin
                case (bii_eff)
                    2'd0:    n_asm[7:0]   = i_byte;
                    2'd1:    n_asm[15:8]  = i_byte;
                    2'd2:    n_asm[23:16] = i_byte;
                    default: n_asm        = r_asm;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PAL;
            r_bii     <= 2'd0;
            r_rem     <= 8'd0;
            r_run     <= 1'b0;
            r_pal_idx <= 9'd0;
        end else begin
            r_phase   <= n_phase;
            r_bii     <= n_bii;
            r_rem     <= n_rem;
            r_run     <= n_run;
            r_pal_idx <= n_pal_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm <= n_asm;
    end

    `TRD_ASSERT_ALWAYS(a_no_write_with_pixel, i_clk, !(o_pal_we && o_job_load), "palette write and pixel in one byte")
    `TRD_ASSERT(a_count_in_range, i_clk, i_rst_n, o_job_load |-> (o_job.count != 8'd0 && o_job.count <= MAX_RUN), "pixel count out of range")

endmodule

[hdl/trd_split.sv]
`include "tga_rle_pixel_decoder_defines.svh"

module trd_split import trd_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_load,
    input  t_job        i_job,
    input  logic [23:0] i_pal_rdata,
    output logic        o_slot_free,
    output logic        o_done,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);

    // pending pixel job
    logic        r_job_valid;
    t_job        r_job;
    logic [7:0]  r_n;
    // raster position and end of image
    logic [12:0] r_col;
    logic [12:0] r_row;
    logic        r_done;
    // output register
    logic        r_out_valid;
    logic [11:0] r_out_row;
    logic [11:0] r_out_col;
    logic [7:0]  r_out_len;
    logic [31:0] r_out_argb;
    logic        r_out_last;
    logic        r_out_done;

    logic [12:0] w, h, h_m1;
    logic        col_wrap;
    logic [12:0] col_e;
    logic [13:0] row_e;
    logic [12:0] room;
    logic        fits, fits_eq, end_row, done_seg, stop, seg_last;
    logic [7:0]  seg;
    logic        out_free, emit;
    logic [31:0] color;
    logic [12:0] flip_row;

    // clamp the image dimensions
    always_comb begin
        if (i_cfg.image_width < MIN_WIDTH) begin
            w = MIN_WIDTH;
        end else if (32'(i_cfg.image_width) > MAX_DIM) begin
            w = 13'(MAX_DIM);
        end else begin
            w = i_cfg.image_width;
        end
        if (i_cfg.image_height < MIN_HEIGHT) begin
            h = MIN_HEIGHT;
        end else if (32'(i_cfg.image_height) > MAX_DIM) begin
            h = 13'(MAX_DIM);
        end else begin
            h = i_cfg.image_height;
        end
    end

    assign h_m1 = h - 13'd1;

    // next segment: clip the remaining count at the row end
    assign col_wrap = (r_col >= w);
    assign col_e    = col_wrap ? 13'd0 : r_col;
    assign row_e    = col_wrap ? ({1'b0, r_row} + 14'd1) : {1'b0, r_row};
    assign stop     = (row_e >= {1'b0, h});
    assign room     = w - col_e;
    assign fits     = ({5'd0, r_n} < room);
    assign fits_eq  = ({5'd0, r_n} <= room);
    assign seg      = fits ? r_n : room[7:0];
    assign end_row  = !fits;
    assign done_seg = end_row && (row_e == {1'b0, h_m1});
    assign seg_last = fits_eq || done_seg;
    assign flip_row = h_m1 - row_e[12:0];

    assign color = r_job.indexed ?
                   {ALPHA_OPAQUE, (r_job.index_oob ? 24'd0 : i_pal_rdata)} : r_job.argb;

    assign out_free    = !r_out_valid || i_m_tready;
    assign emit        = r_job_valid && !r_done && !stop && out_free;
    assign o_slot_free = !r_job_valid || r_done || stop || (emit && seg_last);
    assign o_done      = r_done;

    // job slot and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_col       <= 13'd0;
            r_row       <= 13'd0;
            r_done      <= 1'b0;
        end else begin
            if (r_job_valid && (r_done || stop)) begin
                r_job_valid <= 1'b0;
                r_done      <= 1'b1;
            end else if (emit) begin
                r_col <= end_row ? 13'd0 : (col_e + {5'd0, seg});
                r_row <= end_row ? (row_e[12:0] + 13'd1) : row_e[12:0];
                if (seg_last) begin
                    r_job_valid <= 1'b0;
                end
                if (done_seg) begin
                    r_done <= 1'b1;
                end
            end
            if (i_job_load) begin
                r_job_valid <= 1'b1;
            end
        end
    end

    // job payload and remaining count
    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
            r_n   <= i_job.count;
        end else if (emit) begin
            r_n <= r_n - seg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row  <= i_cfg.top_down ? row_e[11:0] : flip_row[11:0];
            r_out_col  <= col_e[11:0];
            r_out_len  <= seg;
            r_out_argb <= color;
            r_out_last <= seg_last;
            r_out_done <= done_seg;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_argb, r_out_len, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    `TRD_ASSERT(a_done_is_last, i_clk, i_rst_n, r_out_valid && r_out_done |-> r_out_last, "image end not on last segment")
    `TRD_ASSERT(a_quiet_after_done, i_clk, i_rst_n, r_done && !r_out_valid |=> !r_out_valid, "segment after image end")
    `TRD_ASSERT(a_seg_len, i_clk, i_rst_n, r_out_valid |-> (r_out_len != 8'd0 && r_out_len <= MAX_RUN), "segment length out of range")

endmodule

[hdl/tga_rle_pixel_decoder.sv]
// Channel     Dir  Signals                     Payload
// s stream    in   i_s_tvalid/o_s_tready       tdata: data_byte
// m stream    out  o_m_tvalid/i_m_tready       tdata: dest_row, start_column, run_length,
//                                              argb_color; tlast: last; tuser: image_done
// config      in   i_cfg_we/i_cfg_idx          i_cfg_data, no read-back
//
// One byte per cycle while each byte yields at most one segment and the output is not
// stalled. A byte whose pixel splits into several segments holds the input until its
// last segment is out: the splitter emits one segment per cycle into the output register
// while it is free. Indexed pixels read the palette RAM on acceptance. Reset is
// synchronous, with no clearing pass; palette entries are undefined until loaded. A
// stalled output stalls the splitter and then the input once its single-job slot is busy.
module tga_rle_pixel_decoder import trd_pkg::*; #(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    // segment stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [11:0] dest_row, [23:12] start_column,
                                     // [31:24] run_length, [63:32] argb_color
    output logic        o_m_tlast,   // last
    output logic        o_m_tuser    // [0] image_done
);

    localparam int PAW = PALETTE_DEPTH > 1 ? $clog2(PALETTE_DEPTH) : 1;

    t_cfg            r_cfg;
    logic            accept;
    logic            slot_free;
    logic            done;
    logic            job_load;
    t_job            job;
    logic            pal_we;
    logic [PAW-1:0]  pal_waddr;
    logic [23:0]     pal_wdata;
    logic            pal_re;
    logic [PAW-1:0]  pal_raddr;
    logic [23:0]     pal_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_kind      <= KIND_RAW_TRUE;
            r_cfg.pixel_size_code <= PSIZE_BGR;
            r_cfg.image_width     <= 13'd4;
            r_cfg.image_height    <= 13'd1;
            r_cfg.top_down        <= 1'b0;
            r_cfg.palette_count   <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_KIND:    r_cfg.image_kind      <= i_cfg_data[1:0];
                CFG_PIXEL_SIZE:    r_cfg.pixel_size_code <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width     <= i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_cfg.image_height    <= i_cfg_data;
                CFG_TOP_DOWN:      r_cfg.top_down        <= i_cfg_data[0];
                CFG_PALETTE_COUNT: r_cfg.palette_count   <= i_cfg_data[8:0];
                default:           r_cfg                 <= r_cfg;
            endcase
        end
    end

    // input transaction; bytes after the image end are dropped
    assign o_s_tready = slot_free;
    assign accept     = i_s_tvalid && slot_free && !done;

    trd_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_job_load  (job_load),
        .o_job       (job),
        .o_pal_we    (pal_we),
        .o_pal_waddr (pal_waddr),
        .o_pal_wdata (pal_wdata),
        .o_pal_re    (pal_re),
        .o_pal_raddr (pal_raddr)
    );

    trd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_re    (pal_re),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    trd_split #(
        .MAX_DIM (MAX_DIM)
    ) u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_load  (job_load),
        .i_job       (job),
        .i_pal_rdata (pal_rdata),
        .o_slot_free (slot_free),
        .o_done      (done),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
